// ===== hdl/tbp_pkg.sv =====
// Shared constants, types and helper functions of the tournament branch predictor.
// Used by tournament_branch_predictor_core; depends on nothing else.
package tbp_pkg;

   localparam int MAX_GLOBAL_BITS = 13;
   localparam int MAX_LOCAL_BITS  = 11;
   localparam int MAX_PC_BITS     = 11;

   localparam int GLOBAL_DEPTH = 1 << MAX_GLOBAL_BITS;
   localparam int LOCAL_DEPTH  = 1 << MAX_LOCAL_BITS;
   localparam int PC_DEPTH     = 1 << MAX_PC_BITS;

   // clear sweep covers the deepest table; smaller ones wrap harmlessly
   localparam int CLR_BITS = (MAX_GLOBAL_BITS > MAX_LOCAL_BITS)
                             ? ((MAX_GLOBAL_BITS > MAX_PC_BITS) ? MAX_GLOBAL_BITS : MAX_PC_BITS)
                             : ((MAX_LOCAL_BITS > MAX_PC_BITS) ? MAX_LOCAL_BITS : MAX_PC_BITS);

   localparam int CSR_DATA_W = 4;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_HISTORY_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCAL_HISTORY_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PC_INDEX_BITS       = 2'd2;

   localparam logic [CSR_DATA_W-1:0] GLOBAL_BITS_RESET = 4'd9;
   localparam logic [CSR_DATA_W-1:0] LOCAL_BITS_RESET  = 4'd10;
   localparam logic [CSR_DATA_W-1:0] PC_BITS_RESET     = 4'd10;

   typedef logic [1:0] ctr_type;

   localparam ctr_type WEAK_NOT_TAKEN = 2'd1;
   localparam ctr_type CTR_MAX        = 2'd3;
   localparam ctr_type CTR_MIN        = 2'd0;

   typedef struct packed {
      ctr_type choice;
      ctr_type glob;
   } gc_entry_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LHIST,
      ST_COUNT
   } state_type;

   // saturating 2-bit counter step
   function automatic ctr_type train2(input ctr_type c, input logic up);
      ctr_type r;
      if (up) begin
         r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
      end else begin
         r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
      end
      return r;
   endfunction

   // low-bit masks; a count above the width yields all ones
   function automatic logic [MAX_GLOBAL_BITS-1:0] gmask_f(input logic [CSR_DATA_W-1:0] n);
      logic [MAX_GLOBAL_BITS-1:0] m;
      for (int i = 0; i < MAX_GLOBAL_BITS; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

   function automatic logic [MAX_LOCAL_BITS-1:0] lmask_f(input logic [CSR_DATA_W-1:0] n);
      logic [MAX_LOCAL_BITS-1:0] m;
      for (int i = 0; i < MAX_LOCAL_BITS; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

   function automatic logic [MAX_PC_BITS-1:0] pmask_f(input logic [CSR_DATA_W-1:0] n);
      logic [MAX_PC_BITS-1:0] m;
      for (int i = 0; i < MAX_PC_BITS; i++) begin
         m[i] = (i < int'(n));
      end
      return m;
   endfunction

endpackage

// ===== hdl/tournament_branch_predictor_core.sv =====
// After ST_LHIST, the write-back in ST_COUNT loads the output register and
// waits while it is full. Branches are accepted only in ST_IDLE, after the
// dependent reads (local history table, then local counter table) and the
// write-back. Reset is synchronous and starts a clearing sweep setting
// every table entry to its initial value, with req_ready low throughout.
// Uses tbp_pkg; holds the counter and history memories and their control.
module tournament_branch_predictor_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [31:0]                     req_branch_pc,
   input  logic                            req_taken,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_prediction,
   output logic                            rsp_global_guess,
   output logic                            rsp_local_guess,
   output logic                            rsp_chose_local,
   input  logic                            csr_wr_en,
   input  logic [tbp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tbp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tbp_pkg::*;

   // configuration
   logic [CSR_DATA_W-1:0] gbits_ff, lbits_ff, pbits_ff;

   // control
   state_type state_ff, state_in;
   logic [CLR_BITS-1:0] clr_cnt_ff;
   logic accept, clearing, count_done, lc_re;

   // per-item registers
   logic [MAX_GLOBAL_BITS-1:0] global_history_ff;
   logic [MAX_GLOBAL_BITS-1:0] gidx_ff;
   logic [MAX_PC_BITS-1:0]     pidx_ff;
   logic [MAX_LOCAL_BITS-1:0]  lidx_ff;
   logic                       taken_ff;

   // memories and read data
   gc_entry_type              gc_mem [GLOBAL_DEPTH];
   logic [MAX_LOCAL_BITS-1:0] lh_mem [PC_DEPTH];
   ctr_type                   lc_mem [LOCAL_DEPTH];
   gc_entry_type              gc_rd_ff;
   logic [MAX_LOCAL_BITS-1:0] lh_rd_ff;
   ctr_type                   lc_rd_ff;

   // datapath
   logic [MAX_GLOBAL_BITS-1:0] gidx;
   logic [MAX_PC_BITS-1:0]     pidx;
   logic [MAX_LOCAL_BITS-1:0]  lidx;
   logic gguess, lguess, use_local, pred;
   gc_entry_type gc_new;
   ctr_type      lc_new;
   logic [MAX_LOCAL_BITS-1:0] lh_new;

   gc_entry_type              gc_wdata;
   logic [MAX_GLOBAL_BITS-1:0] gc_waddr;
   logic [MAX_LOCAL_BITS-1:0] lh_wdata;
   logic [MAX_PC_BITS-1:0]    lh_waddr;
   ctr_type                   lc_wdata;
   logic [MAX_LOCAL_BITS-1:0] lc_waddr;
   logic                      mem_we;

   logic rsp_valid_ff, pred_ff, gguess_ff, lguess_ff, chose_local_ff;

   // ---------------- configuration registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         gbits_ff <= GLOBAL_BITS_RESET;
         lbits_ff <= LOCAL_BITS_RESET;
         pbits_ff <= PC_BITS_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GLOBAL_HISTORY_BITS: gbits_ff <= csr_wdata;
            CSR_LOCAL_HISTORY_BITS:  lbits_ff <= csr_wdata;
            CSR_PC_INDEX_BITS:       pbits_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- state machine ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == {CLR_BITS{1'b1}}) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_LHIST;
         end
         ST_LHIST: state_in = ST_COUNT;
         ST_COUNT: begin
            if (count_done) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE);
      accept     = req_valid & req_ready;
      clearing   = (state_ff == ST_CLEAR);
      lc_re      = (state_ff == ST_LHIST);
      // hold the finished item until the output register is free
      count_done = (state_ff == ST_COUNT) && (!rsp_valid_ff || rsp_ready);
      mem_we     = clearing | count_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   // ---------------- index and training logic ----------------
   always_comb begin
      gidx = global_history_ff & gmask_f(gbits_ff);
      pidx = req_branch_pc[MAX_PC_BITS-1:0] & pmask_f(pbits_ff);
      lidx = lh_rd_ff & lmask_f(lbits_ff);

      gguess    = gc_rd_ff.glob[1];
      lguess    = lc_rd_ff[1];
      use_local = gc_rd_ff.choice[1];
      pred      = use_local ? lguess : gguess;

      gc_new.glob   = train2(gc_rd_ff.glob, taken_ff);
      gc_new.choice = gc_rd_ff.choice;
      if (gguess == taken_ff && lguess != taken_ff) begin
         gc_new.choice = train2(gc_rd_ff.choice, 1'b0);
      end else if (gguess != taken_ff && lguess == taken_ff) begin
         gc_new.choice = train2(gc_rd_ff.choice, 1'b1);
      end
      lc_new = train2(lc_rd_ff, taken_ff);
      lh_new = MAX_LOCAL_BITS'({lh_rd_ff, taken_ff});

      if (clearing) begin
         gc_waddr        = clr_cnt_ff[MAX_GLOBAL_BITS-1:0];
         gc_wdata.choice = WEAK_NOT_TAKEN;
         gc_wdata.glob   = WEAK_NOT_TAKEN;
         lh_waddr        = clr_cnt_ff[MAX_PC_BITS-1:0];
         lh_wdata        = '0;
         lc_waddr        = clr_cnt_ff[MAX_LOCAL_BITS-1:0];
         lc_wdata        = WEAK_NOT_TAKEN;
      end else begin
         gc_waddr = gidx_ff;
         gc_wdata = gc_new;
         lh_waddr = pidx_ff;
         lh_wdata = lh_new;
         lc_waddr = lidx_ff;
         lc_wdata = lc_new;
      end
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (mem_we) gc_mem[gc_waddr] <= gc_wdata;
      if (accept) gc_rd_ff <= gc_mem[gidx];
   end

   always_ff @(posedge clock) begin
      if (mem_we) lh_mem[lh_waddr] <= lh_wdata;
      if (accept) lh_rd_ff <= lh_mem[pidx];
   end

   always_ff @(posedge clock) begin
      if (mem_we) lc_mem[lc_waddr] <= lc_wdata;
      if (lc_re) lc_rd_ff <= lc_mem[lidx];
   end

   // ---------------- item registers ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         gidx_ff  <= gidx;
         pidx_ff  <= pidx;
         taken_ff <= req_taken;
      end
      if (lc_re) lidx_ff <= lidx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         global_history_ff <= '0;
      end else if (count_done) begin
         global_history_ff <= MAX_GLOBAL_BITS'({global_history_ff, taken_ff});
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (count_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (count_done) begin
         pred_ff        <= pred;
         gguess_ff      <= gguess;
         lguess_ff      <= lguess;
         chose_local_ff <= use_local;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prediction   = pred_ff;
   assign rsp_global_guess = gguess_ff;
   assign rsp_local_guess  = lguess_ff;
   assign rsp_chose_local  = chose_local_ff;

   // ---------------- assertions ----------------
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("request accepted during clearing sweep");

   a_write_only_at_writeback: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_COUNT))
      else $error("table write outside clear or write-back");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      count_done |=> rsp_valid_ff)
      else $error("finished item did not reach the output register");

   a_history_shift: assert property (@(posedge clock) disable iff (reset)
      count_done |=> global_history_ff ==
         MAX_GLOBAL_BITS'({$past(global_history_ff), $past(taken_ff)}))
      else $error("global history not shifted with the outcome");

   a_lhist_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LHIST)
      else $error("accepted beat did not start the lookup");

endmodule

// ===== sim/tb_tournament_branch_predictor_core.sv =====
// Self-checking testbench for tournament_branch_predictor_core.
// Drives resolved branches and register writes, and scores every guess
// against a behavioral predictor. Depends on tbp_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_tournament_branch_predictor_core;
   import tbp_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          NUM_SETTINGS = 6;
   localparam int          ITEMS_PER_SETTING = 75;
   localparam int          HOT_BRANCHES = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef struct {
      logic [31:0] pc;
      logic        taken;
   } branch_type;

   typedef struct {
      logic prediction;
      logic global_guess;
      logic local_guess;
      logic chose_local;
   } guess_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [31:0]           req_branch_pc = '0;
   logic                  req_taken = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_prediction;
   logic                  rsp_global_guess;
   logic                  rsp_local_guess;
   logic                  rsp_chose_local;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   branch_type  branch_queue[$];
   guess_type   expected_guesses[$];
   logic        req_accepted = 1'b0;
   logic        send_hold = 1'b0;
   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;
   int          error_count = 0;
   int          guesses_checked = 0;
   int          csr_writes = 0;
   int unsigned cycle_count = 0;

   // behavioral predictor state
   ctr_type                    global_ctr [GLOBAL_DEPTH];
   ctr_type                    choice_ctr [GLOBAL_DEPTH];
   ctr_type                    local_ctr  [LOCAL_DEPTH];
   logic [MAX_LOCAL_BITS-1:0]  local_hist [PC_DEPTH];
   logic [MAX_GLOBAL_BITS-1:0] global_hist;
   logic [CSR_DATA_W-1:0]      cfg_global_bits;
   logic [CSR_DATA_W-1:0]      cfg_local_bits;
   logic [CSR_DATA_W-1:0]      cfg_pc_bits;

   // hot branches give the local histories something to learn
   logic [31:0] hot_pc     [HOT_BRANCHES];
   int          hot_period [HOT_BRANCHES];
   int          hot_count  [HOT_BRANCHES];

   tournament_branch_predictor_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_branch_pc    (req_branch_pc),
      .req_taken        (req_taken),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_prediction   (rsp_prediction),
      .rsp_global_guess (rsp_global_guess),
      .rsp_local_guess  (rsp_local_guess),
      .rsp_chose_local  (rsp_chose_local),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int unsigned low_bits(input logic [CSR_DATA_W-1:0] n, input int limit);
      int k;
      k = (int'(n) > limit) ? limit : int'(n);
      return (32'd1 << k) - 32'd1;
   endfunction

   function automatic ctr_type saturate_step(input ctr_type c, input logic up);
      if (up) begin
         return (c == 2'd3) ? 2'd3 : c + 2'd1;
      end
      return (c == 2'd0) ? 2'd0 : c - 2'd1;
   endfunction

   task automatic resolve_branch(input logic [31:0] pc, input logic taken, output guess_type g);
      int unsigned gi;
      int unsigned pi;
      int unsigned li;
      logic        gg;
      logic        lg;
      gi = global_hist & low_bits(cfg_global_bits, MAX_GLOBAL_BITS);
      pi = pc & low_bits(cfg_pc_bits, MAX_PC_BITS);
      li = local_hist[pi] & low_bits(cfg_local_bits, MAX_LOCAL_BITS);
      gg = (global_ctr[gi] >= 2'd2);
      lg = (local_ctr[li] >= 2'd2);
      g.global_guess = gg;
      g.local_guess  = lg;
      g.chose_local  = (choice_ctr[gi] >= 2'd2);
      g.prediction   = g.chose_local ? lg : gg;
      global_ctr[gi] = saturate_step(global_ctr[gi], taken);
      local_ctr[li]  = saturate_step(local_ctr[li], taken);
      // move the chooser only when exactly one side was right
      if (gg == taken && lg != taken) begin
         choice_ctr[gi] = saturate_step(choice_ctr[gi], 1'b0);
      end else if (gg != taken && lg == taken) begin
         choice_ctr[gi] = saturate_step(choice_ctr[gi], 1'b1);
      end
      local_hist[pi] = {local_hist[pi][MAX_LOCAL_BITS-2:0], taken};
      global_hist    = {global_hist[MAX_GLOBAL_BITS-2:0], taken};
   endtask

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0b, got %0b", $time, name, want, got);
         error_count++;
      end
   endtask

   // monitor and scoreboard
   always @(posedge clock) begin : monitor
      guess_type g;
      guess_type want;
      if (reset) begin
         req_accepted <= 1'b0;
         for (int i = 0; i < GLOBAL_DEPTH; i++) begin
            global_ctr[i] = WEAK_NOT_TAKEN;
            choice_ctr[i] = WEAK_NOT_TAKEN;
         end
         for (int i = 0; i < LOCAL_DEPTH; i++) begin
            local_ctr[i] = WEAK_NOT_TAKEN;
         end
         for (int i = 0; i < PC_DEPTH; i++) begin
            local_hist[i] = '0;
         end
         global_hist     = '0;
         cfg_global_bits = GLOBAL_BITS_RESET;
         cfg_local_bits  = LOCAL_BITS_RESET;
         cfg_pc_bits     = PC_BITS_RESET;
      end else begin
         req_accepted <= req_valid && req_ready;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GLOBAL_HISTORY_BITS: cfg_global_bits = csr_wdata;
               CSR_LOCAL_HISTORY_BITS:  cfg_local_bits  = csr_wdata;
               CSR_PC_INDEX_BITS:       cfg_pc_bits     = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            resolve_branch(req_branch_pc, req_taken, g);
            expected_guesses.push_back(g);
         end
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_guesses.size() == 0) begin
               $display("%0t ns: result beat with nothing expected, got pred %0b",
                        $time, rsp_prediction);
               error_count++;
            end else begin
               want = expected_guesses.pop_front();
               check_field("prediction", want.prediction, rsp_prediction);
               check_field("global_guess", want.global_guess, rsp_global_guess);
               check_field("local_guess", want.local_guess, rsp_local_guess);
               check_field("chose_local", want.chose_local, rsp_chose_local);
               guesses_checked++;
            end
         end
      end
   end

   // request driver: hold the beat until accepted, then maybe present the next
   always @(negedge clock) begin : driver
      branch_type b;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (!send_hold && branch_queue.size() != 0 &&
             $urandom_range(0, 99) >= sender_idle_pct) begin
            b = branch_queue.pop_front();
            req_valid     <= 1'b1;
            req_branch_pc <= b.pc;
            req_taken     <= b.taken;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic push_branch(input logic [31:0] pc, input logic taken);
      branch_type b;
      b.pc    = pc;
      b.taken = taken;
      branch_queue.push_back(b);
   endtask

   task automatic queue_random_branches(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) != 0) begin
            // loop-like branch: taken except once per period, with rare noise
            k = $urandom_range(0, HOT_BRANCHES - 1);
            hot_count[k]++;
            push_branch(hot_pc[k], ((hot_count[k] % hot_period[k]) != 0) ^
                                   ($urandom_range(0, 15) == 0));
         end else begin
            push_branch($urandom, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_writes++;
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (branch_queue.size() != 0 || req_valid || expected_guesses.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : stimulus
      logic [CSR_DATA_W-1:0] set_global [NUM_SETTINGS];
      logic [CSR_DATA_W-1:0] set_local  [NUM_SETTINGS];
      logic [CSR_DATA_W-1:0] set_pc     [NUM_SETTINGS];
      // narrowest, widest, zero, above the maximum, mixed, random
      set_global = '{4'd1, 4'd13, 4'd0, 4'd15, 4'd5, 4'd0};
      set_local  = '{4'd1, 4'd11, 4'd0, 4'd15, 4'd3, 4'd0};
      set_pc     = '{4'd1, 4'd11, 4'd0, 4'd15, 4'd7, 4'd0};
      set_global[NUM_SETTINGS-1] = CSR_DATA_W'($urandom_range(0, 15));
      set_local[NUM_SETTINGS-1]  = CSR_DATA_W'($urandom_range(0, 15));
      set_pc[NUM_SETTINGS-1]     = CSR_DATA_W'($urandom_range(0, 15));

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      // wait out the table clearing sweep
      @(posedge clock);
      while (!req_ready) @(posedge clock);

      sender_idle_pct   = 27;
      receiver_idle_pct = 48;
      push_branch(32'h0000_0000, 1'b0);
      push_branch(32'hFFFF_FFFF, 1'b1);
      repeat (5) push_branch(32'h0000_0400, 1'b1);
      repeat (5) push_branch(32'h0000_0400, 1'b0);
      repeat (3) begin
         push_branch(32'hAAAA_AAAA, 1'b1);
         push_branch(32'h5555_5555, 1'b0);
      end
      push_branch(32'h8000_0000, 1'b1);
      push_branch(32'h7FFF_FFFF, 1'b0);
      wait_drained();

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         if (s < 2) begin
            sender_idle_pct   = 27;
            receiver_idle_pct = 48;
         end else if (s < 4) begin
            sender_idle_pct   = 48;
            receiver_idle_pct = 27;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         // an unmapped index must leave every register alone
         if (s == 4) write_reg(CSR_UNUSED_INDEX, 4'hF);
         write_reg(CSR_GLOBAL_HISTORY_BITS, set_global[s]);
         write_reg(CSR_LOCAL_HISTORY_BITS, set_local[s]);
         write_reg(CSR_PC_INDEX_BITS, set_pc[s]);
         for (int k = 0; k < HOT_BRANCHES; k++) begin
            hot_pc[k]     = $urandom;
            hot_period[k] = $urandom_range(2, 9);
            hot_count[k]  = 0;
         end
         if (s == 1) begin
            queue_random_branches(ITEMS_PER_SETTING / 2);
            @(posedge clock);
            while (branch_queue.size() != 0) @(posedge clock);
            // hold new requests until every outstanding guess is back
            send_hold = 1'b1;
            queue_random_branches(ITEMS_PER_SETTING - ITEMS_PER_SETTING / 2);
            @(posedge clock);
            while (req_valid || expected_guesses.size() != 0) @(posedge clock);
            send_hold = 1'b0;
         end else begin
            queue_random_branches(ITEMS_PER_SETTING);
         end
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Scored %0d branch guesses across %0d register settings (%0d writes),",
               guesses_checked, NUM_SETTINGS + 1, csr_writes);
      $display("including zero, minimum, maximum and oversized history widths.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/tbp_pkg.sv
hdl/tournament_branch_predictor_core.sv
sim/tb_tournament_branch_predictor_core.sv
